[rtl/core/esc_pkg.sv]
`timescale 1ns / 1ps

package esc_pkg;

  // Field and datapath widths.
  localparam int SECONDS_WIDTH   = 32;
  localparam int ZONE_WIDTH      = 11;
  localparam int ADJ_WIDTH       = SECONDS_WIDTH + 2;
  localparam int DAYS_WIDTH      = SECONDS_WIDTH - 16;
  localparam int REM_WIDTH       = 18;
  localparam int TOD_WIDTH       = 17;
  localparam int MINUTES_WIDTH   = 11;
  localparam int IN_TDATA_WIDTH  = ((SECONDS_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS_BITS = 46;
  localparam int OUT_TDATA_WIDTH = ((OUT_FIELDS_BITS + 7) / 8) * 8;

  // Reciprocal divider: operand, reciprocal and product widths, and its step count.
  localparam int DIV_X_WIDTH     = SECONDS_WIDTH - 7;
  localparam int DIV_M_WIDTH     = SECONDS_WIDTH - 16;
  localparam int PROD_WIDTH      = DIV_X_WIDTH + DIV_M_WIDTH;
  localparam int DIV_STEPS       = 3;
  localparam int CNT_WIDTH       = 2;

  // The power-of-two factors of 86400 and 60 are split off as plain bit fields.
  localparam int DAY_SHIFT         = 7;
  localparam int SIXTY_SHIFT       = 2;
  localparam int DAY_RECIP_SHIFT   = SECONDS_WIDTH - DAY_SHIFT;
  localparam int SIXTY_RECIP_SHIFT = 15;
  localparam int WEEK_RECIP_SHIFT  = DAYS_WIDTH + 1;
  localparam int CYCLE_RECIP_SHIFT = DAYS_WIDTH;

  // Calendar constants.
  localparam logic [REM_WIDTH-1:0] DAY_DIVISOR   = REM_WIDTH'((24 * 60 * 60) >> DAY_SHIFT);
  localparam logic [REM_WIDTH-1:0] SIXTY_DIVISOR = REM_WIDTH'(60 >> SIXTY_SHIFT);
  localparam logic [REM_WIDTH-1:0] CYCLE_DAYS   = REM_WIDTH'(146097);
  localparam logic [REM_WIDTH-1:0] WEEK_DAYS    = REM_WIDTH'(7);
  localparam logic [2:0]           EPOCH_WEEKDAY = 3'd4;
  localparam logic [7:0]           EPOCH_YEARS_SINCE_1900 = 8'(1970 - 1900);
  localparam logic [7:0]           CYCLE_YEARS_LOW = 8'(400 % 256);
  localparam logic [8:0]           EPOCH_YEAR_MOD400 = 9'(1970 % 400);
  localparam logic [8:0]           LAST_MOD400 = 9'(400 - 1);
  localparam logic [8:0]           DAYS_LEAP = 9'd366;
  localparam logic [8:0]           DAYS_COMMON = 9'd365;
  localparam logic [8:0]           LAST_FEB_DAY = 9'd58;
  localparam logic [8:0]           LEAP_DAY = 9'd59;

  // Rounded-down reciprocals, 2^k / d, for operands below 2^k.
  localparam logic [DIV_M_WIDTH-1:0] DAY_RECIP =
      DIV_M_WIDTH'((longint'(1) << DAY_RECIP_SHIFT) / ((24 * 60 * 60) >> DAY_SHIFT));
  localparam logic [DIV_M_WIDTH-1:0] SIXTY_RECIP =
      DIV_M_WIDTH'((longint'(1) << SIXTY_RECIP_SHIFT) / (60 >> SIXTY_SHIFT));
  localparam logic [DIV_M_WIDTH-1:0] WEEK_RECIP =
      DIV_M_WIDTH'((longint'(1) << WEEK_RECIP_SHIFT) / 7);
  localparam logic [DIV_M_WIDTH-1:0] CYCLE_RECIP =
      DIV_M_WIDTH'((longint'(1) << CYCLE_RECIP_SHIFT) / 146097);

  // Divisions run by the shared divider, in this order.
  typedef enum logic [2:0] {
    DIV_DAY,
    DIV_SEC,
    DIV_MIN,
    DIV_WDAY,
    DIV_CYCLE
  } div_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_YEAR,
    ST_MONTH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    div_init;
    logic    div_step;
    logic    div_save;
    div_op_t op;
    logic    year_step;
    logic    month_calc;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_done;
  } dp_status_t;

  function automatic logic [REM_WIDTH-1:0] div_divisor(input div_op_t op);
    logic [REM_WIDTH-1:0] d;
    unique case (op)
      DIV_DAY:   d = DAY_DIVISOR;
      DIV_SEC:   d = SIXTY_DIVISOR;
      DIV_MIN:   d = SIXTY_DIVISOR;
      DIV_WDAY:  d = WEEK_DAYS;
      DIV_CYCLE: d = CYCLE_DAYS;
      default:   d = DAY_DIVISOR;
    endcase
    return d;
  endfunction

  function automatic logic [DIV_M_WIDTH-1:0] div_recip(input div_op_t op);
    logic [DIV_M_WIDTH-1:0] m;
    unique case (op)
      DIV_DAY:   m = DAY_RECIP;
      DIV_SEC:   m = SIXTY_RECIP;
      DIV_MIN:   m = SIXTY_RECIP;
      DIV_WDAY:  m = WEEK_RECIP;
      DIV_CYCLE: m = CYCLE_RECIP;
      default:   m = DAY_RECIP;
    endcase
    return m;
  endfunction

  // Quotient estimate from the product; it is low by at most one.
  function automatic logic [DAYS_WIDTH-1:0] div_quotient(input div_op_t op,
                                                         input logic [PROD_WIDTH-1:0] p);
    logic [DAYS_WIDTH-1:0] q;
    unique case (op)
      DIV_DAY:   q = DAYS_WIDTH'(p >> DAY_RECIP_SHIFT);
      DIV_SEC:   q = DAYS_WIDTH'(p >> SIXTY_RECIP_SHIFT);
      DIV_MIN:   q = DAYS_WIDTH'(p >> SIXTY_RECIP_SHIFT);
      DIV_WDAY:  q = DAYS_WIDTH'(p >> WEEK_RECIP_SHIFT);
      DIV_CYCLE: q = DAYS_WIDTH'(p >> CYCLE_RECIP_SHIFT);
      default:   q = '0;
    endcase
    return q;
  endfunction

  // Days in the year before the first of each month, common year.
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Last month whose first day is at or before the given day of year.
  function automatic logic [3:0] month_index(input logic [8:0] w);
    logic [3:0] m;
    m = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (days_before_month(4'(i)) <= w) begin
        m = 4'(i);
      end
    end
    return m;
  endfunction

  // Gregorian leap rule from the year modulo 400.
  function automatic logic is_leap(input logic [8:0] m400);
    return (m400[1:0] == 2'b00) && (m400 != 9'd100) && (m400 != 9'd200)
           && (m400 != 9'd300);
  endfunction

endpackage

[rtl/core/esc_ctrl.sv]
`timescale 1ns / 1ps

module esc_ctrl
  import esc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t  state, state_next;
  div_op_t op, op_next;
  logic    m_tvalid_next;

  // State, current division and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= DIV_DAY;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      op       <= op_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    op_next       = op;
    cmd           = '0;
    cmd.op        = op;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
        if (s_tvalid) begin
          op_next    = DIV_DAY;
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.div_save = 1'b1;
          unique case (op)
            DIV_DAY: begin
              op_next    = DIV_SEC;
              state_next = ST_DIV_INIT;
            end
            DIV_SEC: begin
              op_next    = DIV_MIN;
              state_next = ST_DIV_INIT;
            end
            DIV_MIN: begin
              op_next    = DIV_WDAY;
              state_next = ST_DIV_INIT;
            end
            DIV_WDAY: begin
              op_next    = DIV_CYCLE;
              state_next = ST_DIV_INIT;
            end
            DIV_CYCLE: begin
              state_next = ST_YEAR;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_YEAR: begin
        if (status.year_done) begin
          state_next = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        cmd.month_calc = 1'b1;
        state_next     = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/esc_datapath.sv]
`timescale 1ns / 1ps

module esc_datapath
  import esc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [ZONE_WIDTH-1:0]     cfg_wdata,
  input  logic [SECONDS_WIDTH-1:0]  epoch_seconds,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  output logic [5:0]                second_of_minute,
  output logic [5:0]                minute_of_hour,
  output logic [4:0]                hour_of_day,
  output logic [2:0]                day_of_week,
  output logic [7:0]                years_since_1900,
  output logic [8:0]                day_of_year,
  output logic [4:0]                day_of_month,
  output logic [3:0]                month_of_year,
  output logic                      range_clamped
);

  logic [ZONE_WIDTH-1:0]    zone;
  logic [SECONDS_WIDTH-1:0] t;
  logic                     clamped;
  logic [DIV_X_WIDTH-1:0]   dvd;
  logic [PROD_WIDTH-1:0]    prod;
  logic [DAYS_WIDTH-1:0]    quot;
  logic [REM_WIDTH:0]       rem;
  logic [CNT_WIDTH-1:0]     cnt;
  logic [DAYS_WIDTH-1:0]    days;
  logic [TOD_WIDTH-1:0]     tod;
  logic [MINUTES_WIDTH-1:0] minutes;
  logic [5:0]               sec;
  logic [5:0]               min;
  logic [4:0]               hour;
  logic [2:0]               wday;
  logic [7:0]               year;
  logic [8:0]               m400;
  logic [REM_WIDTH-1:0]     work;
  logic [3:0]               mon;
  logic [4:0]               mday;

  logic [ADJ_WIDTH-1:0]     zone_ext;
  logic [ADJ_WIDTH-1:0]     zone_sec;
  logic [ADJ_WIDTH-1:0]     adj;
  logic [REM_WIDTH-1:0]     divisor;
  logic [DIV_M_WIDTH-1:0]   recip;
  logic [DIV_X_WIDTH-1:0]   quot_times_div;
  logic                     corr;
  logic [DAYS_WIDTH-1:0]    quot_fix;
  logic [REM_WIDTH-1:0]     rem_fix;
  logic [DIV_X_WIDTH-1:0]   dividend;
  logic [8:0]               ylen;
  logic                     leap;
  logic [8:0]               doy;
  logic [8:0]               mwork;
  logic [3:0]               mon_calc;
  logic [4:0]               mday_base;

  // Zone offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (cfg_wen) begin
      zone <= cfg_wdata;
    end
  end

  // Zone-adjusted time; the top bit is the sign, the next one an overflow.
  // The offset times 60 is formed as times 64 minus times 4.
  assign zone_ext = {{(ADJ_WIDTH - ZONE_WIDTH){zone[ZONE_WIDTH-1]}}, zone};
  assign zone_sec = (zone_ext << 6) - (zone_ext << 2);
  assign adj      = {2'b00, epoch_seconds} - zone_sec;

  // Reciprocal division: the estimate is low by at most one, so one
  // compare and subtract at save time finishes it.
  assign divisor        = div_divisor(cmd.op);
  assign recip          = div_recip(cmd.op);
  assign quot_times_div = DIV_X_WIDTH'(quot) * DIV_X_WIDTH'(divisor);
  assign corr           = (rem >= {1'b0, divisor});
  assign quot_fix       = quot + DAYS_WIDTH'(corr);
  assign rem_fix        = corr ? REM_WIDTH'(rem - {1'b0, divisor}) : rem[REM_WIDTH-1:0];

  // Operand of the division about to start, with power-of-two factors split off.
  always_comb begin
    unique case (cmd.op)
      DIV_DAY:   dividend = DIV_X_WIDTH'(t >> DAY_SHIFT);
      DIV_SEC:   dividend = DIV_X_WIDTH'(tod >> SIXTY_SHIFT);
      DIV_MIN:   dividend = DIV_X_WIDTH'(minutes >> SIXTY_SHIFT);
      DIV_WDAY:  dividend = DIV_X_WIDTH'(days) + DIV_X_WIDTH'(EPOCH_WEEKDAY);
      DIV_CYCLE: dividend = DIV_X_WIDTH'(days);
      default:   dividend = DIV_X_WIDTH'(t >> DAY_SHIFT);
    endcase
  end

  // Year length and the leap-day fix for the month lookup.
  assign leap      = is_leap(m400);
  assign ylen      = leap ? DAYS_LEAP : DAYS_COMMON;
  assign doy       = work[8:0];
  assign mwork     = (leap && (doy > LAST_FEB_DAY)) ? doy - 9'd1 : doy;
  assign mday_base = (leap && (doy == LEAP_DAY)) ? 5'd2 : 5'd1;
  assign mon_calc  = month_index(mwork);

  assign status.div_done  = (cnt == '0);
  assign status.year_done = (work < REM_WIDTH'(ylen));

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      if (adj[ADJ_WIDTH-1]) begin
        t       <= '0;
        clamped <= 1'b1;
      end else if (adj[ADJ_WIDTH-2]) begin
        t       <= '1;
        clamped <= 1'b1;
      end else begin
        t       <= adj[SECONDS_WIDTH-1:0];
        clamped <= 1'b0;
      end
    end

    // Product, quotient estimate and remainder are registered in turn, each from the one before.
    if (cmd.div_init) begin
      dvd <= dividend;
      cnt <= CNT_WIDTH'(DIV_STEPS);
    end else if (cmd.div_step) begin
      prod <= PROD_WIDTH'(dvd) * PROD_WIDTH'(recip);
      quot <= div_quotient(cmd.op, prod);
      rem  <= (REM_WIDTH + 1)'(dvd - quot_times_div);
      cnt  <= cnt - CNT_WIDTH'(1);
    end

    // Store the quotient and remainder where the division belongs.
    if (cmd.div_save) begin
      unique case (cmd.op)
        DIV_DAY: begin
          days <= quot_fix;
          tod  <= TOD_WIDTH'({rem_fix, t[DAY_SHIFT-1:0]});
        end
        DIV_SEC: begin
          minutes <= MINUTES_WIDTH'(quot_fix);
          sec     <= 6'({rem_fix, tod[SIXTY_SHIFT-1:0]});
        end
        DIV_MIN: begin
          hour <= quot_fix[4:0];
          min  <= 6'({rem_fix, minutes[SIXTY_SHIFT-1:0]});
        end
        DIV_WDAY: begin
          wday <= rem_fix[2:0];
        end
        DIV_CYCLE: begin
          work <= rem_fix;
          year <= quot_fix[7:0] * CYCLE_YEARS_LOW + EPOCH_YEARS_SINCE_1900;
          m400 <= EPOCH_YEAR_MOD400;
        end
        default: begin
          wday <= rem_fix[2:0];
        end
      endcase
    end

    // Walk one year per cycle.
    if (cmd.year_step) begin
      work <= work - REM_WIDTH'(ylen);
      year <= year + 8'd1;
      m400 <= (m400 == LAST_MOD400) ? 9'd0 : m400 + 9'd1;
    end

    if (cmd.month_calc) begin
      mon  <= mon_calc;
      mday <= mday_base + 5'(mwork - days_before_month(mon_calc));
    end

    // Output register.
    if (cmd.out_load) begin
      second_of_minute <= sec;
      minute_of_hour   <= min;
      hour_of_day      <= hour;
      day_of_week      <= wday;
      years_since_1900 <= year;
      day_of_year      <= doy;
      day_of_month     <= mday;
      month_of_year    <= mon;
      range_clamped    <= clamped;
    end
  end

endmodule

[rtl/core/epoch_seconds_to_calendar_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   s_tdata: epoch_seconds
// m_        out        m_tvalid/m_tready   m_tdata: calendar fields, m_tuser: range_clamped
// cfg_      in         cfg_wen             cfg_wdata: zone_minutes_west
//
// One transaction is accepted, then runs the day, second, minute, weekday and 400-year
// divisions in the shared reciprocal divider, walks one year per cycle from the 400-year
// boundary (up to 136 years for 32-bit input), then does the last year check, the month
// lookup and the output load.
// Reset (rst, synchronous) clears the zone offset and the controller; no clearing pass.
// The next input is taken once the result is in the output register, even while
// m_tready is low; a stalled result holds the block before its output load.
module epoch_seconds_to_calendar_top
  import esc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [ZONE_WIDTH-1:0]      cfg_wdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [SECONDS_WIDTH-1:0] epoch_seconds, zero padding above
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [19:17] day_of_week, [27:20] years_since_1900, [36:28] day_of_year,
  // [41:37] day_of_month, [45:42] month_of_year, zero padding above
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  // [0] range_clamped
  output logic                       m_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [5:0] second_of_minute;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [2:0] day_of_week;
  logic [7:0] years_since_1900;
  logic [8:0] day_of_year;
  logic [4:0] day_of_month;
  logic [3:0] month_of_year;

  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  esc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata),
    .epoch_seconds    (s_tdata[SECONDS_WIDTH-1:0]),
    .cmd              (cmd),
    .status           (status),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .day_of_week      (day_of_week),
    .years_since_1900 (years_since_1900),
    .day_of_year      (day_of_year),
    .day_of_month     (day_of_month),
    .month_of_year    (month_of_year),
    .range_clamped    (m_tuser)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = OUT_TDATA_WIDTH'({month_of_year, day_of_month, day_of_year,
                                     years_since_1900, day_of_week, hour_of_day,
                                     minute_of_hour, second_of_minute});

endmodule

[test/tb_epoch_seconds_to_calendar_top.sv]
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_top;
  import esc_pkg::*;

  localparam longint SECONDS_TOP = (longint'(1) << SECONDS_WIDTH) - 1;
  localparam int     RANDOM_PER_PHASE = 62;
  localparam int     PHASES = 8;

  // First day of each month in a common year, zero based.
  localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // One broken-down calendar time as the block reports it.
  typedef struct {
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [2:0] day_of_week;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [4:0] day_of_month;
    logic [3:0] month_of_year;
    logic       range_clamped;
  } calendar_t;

  // Keeps the zone offset, converts each accepted timestamp and checks results in order.
  class calendar_scoreboard;
    logic signed [ZONE_WIDTH-1:0] zone;
    calendar_t expected_dates[$];
    int errors;

    function new();
      zone = '0;
      errors = 0;
    endfunction

    static function bit leap(int year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    function calendar_t to_calendar(logic [SECONDS_WIDTH-1:0] secs);
      calendar_t c;
      longint zone_secs, adj, t, tod, days, work;
      int year, mon, mday;
      zone_secs = zone;
      zone_secs = zone_secs * 60;
      adj = longint'({32'd0, secs}) - zone_secs;
      c.range_clamped = 1'b0;
      if (adj < 0) begin
        t = 0;
        c.range_clamped = 1'b1;
      end else if (adj > SECONDS_TOP) begin
        t = SECONDS_TOP;
        c.range_clamped = 1'b1;
      end else begin
        t = adj;
      end
      tod = t % 86400;
      days = t / 86400;
      c.second_of_minute = 6'(tod % 60);
      c.minute_of_hour = 6'((tod / 60) % 60);
      c.hour_of_day = 5'(tod / 3600);
      c.day_of_week = 3'((days + 4) % 7);

      // Skip whole 400-year spans, then walk single years.
      year = 1970 + 400 * int'(days / 146097);
      work = days % 146097;
      while (work >= (leap(year) ? 366 : 365)) begin
        work -= leap(year) ? 366 : 365;
        year++;
      end
      c.day_of_year = 9'(work);

      // Fold the leap day out so the common-year table applies.
      mday = 1;
      if (leap(year) && work > 58) begin
        if (work == 59) begin
          mday = 2;
        end
        work--;
      end
      mon = 11;
      while (mon > 0 && MONTH_START[mon] > work) begin
        mon--;
      end
      mday += int'(work) - MONTH_START[mon];
      c.years_since_1900 = 8'(year - 1900);
      c.day_of_month = 5'(mday);
      c.month_of_year = 4'(mon);
      return c;
    endfunction

    function void note_input(logic [SECONDS_WIDTH-1:0] secs);
      expected_dates.push_back(to_calendar(secs));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_WIDTH-1:0] tdata, logic tuser);
      calendar_t want;
      if (expected_dates.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %0d", tdata, tuser);
        errors++;
        return;
      end
      want = expected_dates.pop_front();
      compare_field("second_of_minute", want.second_of_minute, tdata[5:0]);
      compare_field("minute_of_hour", want.minute_of_hour, tdata[11:6]);
      compare_field("hour_of_day", want.hour_of_day, tdata[16:12]);
      compare_field("day_of_week", want.day_of_week, tdata[19:17]);
      compare_field("years_since_1900", want.years_since_1900, tdata[27:20]);
      compare_field("day_of_year", want.day_of_year, tdata[36:28]);
      compare_field("day_of_month", want.day_of_month, tdata[41:37]);
      compare_field("month_of_year", want.month_of_year, tdata[45:42]);
      compare_field("range_clamped", want.range_clamped, tuser);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_wen;
  logic [ZONE_WIDTH-1:0]      cfg_wdata;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;
  logic                       m_tuser;
  logic                       quiet;

  calendar_scoreboard sb = new();

  epoch_seconds_to_calendar_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Seconds since the epoch of a given day of year and time of day.
  function automatic longint date_to_seconds(int year, int doy, int tod);
    longint days;
    days = 0;
    for (int y = 1970; y < year; y++) begin
      days += calendar_scoreboard::leap(y) ? 366 : 365;
    end
    return (days + doy) * 86400 + tod;
  endfunction

  // Random timestamp: calendar edges shifted by the zone, raw values and range-edge values.
  function automatic logic [SECONDS_WIDTH-1:0] random_epoch(logic signed [ZONE_WIDTH-1:0] z);
    longint offset, v;
    int year, ylen, doy, tod;
    offset = z;
    offset = offset * 60;
    case ($urandom_range(99) / 10)
      0, 1, 2, 3: v = {$urandom};
      4, 5, 6, 7: begin
        year = $urandom_range(2105, 1970);
        ylen = calendar_scoreboard::leap(year) ? 366 : 365;
        case ($urandom_range(5))
          0: doy = 0;
          1: doy = 58;
          2: doy = 59;
          3: doy = 60;
          4: doy = ylen - 1;
          default: doy = $urandom_range(ylen - 1);
        endcase
        case ($urandom_range(2))
          0: tod = 0;
          1: tod = 86399;
          default: tod = $urandom_range(86399);
        endcase
        v = date_to_seconds(year, doy, tod) + offset;
      end
      8: v = $urandom_range(100000);
      default: v = SECONDS_TOP - $urandom_range(100000);
    endcase
    return v[SECONDS_WIDTH-1:0];
  endfunction

  task automatic set_zone(logic signed [ZONE_WIDTH-1:0] z);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= z;
    @(posedge clk);
    sb.zone = z;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Offers one timestamp, with random idle cycles first unless quiet, and waits for the transaction.
  task automatic send_epoch(longint secs);
    while (!quiet && $urandom_range(99) < 7) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_WIDTH'(secs[SECONDS_WIDTH-1:0]);
    do @(posedge clk); while (!s_tready);
    sb.note_input(secs[SECONDS_WIDTH-1:0]);
  endtask

  // Stops offering input and waits until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_dates.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Result side backpressure.
  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 7);
  end

  // Check every result transaction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
    end
  end

  initial begin
    #10ms;
    $display("epoch_seconds_to_calendar_top: mismatch");
    $finish;
  end

  initial begin
    logic signed [ZONE_WIDTH-1:0] zones [PHASES];
    longint offset;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    quiet = 1'b0;
    zones[0] = 11'sd0;
    zones[1] = 11'sd720;
    zones[2] = -11'sd840;
    zones[3] = -11'sd1024;
    zones[4] = 11'sd1023;
    for (int p = 5; p < PHASES; p++) begin
      zones[p] = ZONE_WIDTH'($urandom);
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 2);
      set_zone(zones[p]);
      if (p == 0) begin
        // Range ends, leap days, a non-leap century and year ends.
        send_epoch(0);
        send_epoch(SECONDS_TOP);
        send_epoch(date_to_seconds(2000, 58, 86399));
        send_epoch(date_to_seconds(2000, 59, 0));
        send_epoch(date_to_seconds(2000, 60, 0));
        send_epoch(date_to_seconds(2100, 58, 86399));
        send_epoch(date_to_seconds(2100, 59, 0));
        send_epoch(date_to_seconds(1972, 365, 86399));
        send_epoch(date_to_seconds(1971, 364, 86399));
        send_epoch(date_to_seconds(2104, 59, 43200));
        send_epoch(date_to_seconds(2105, 364, 86399));
      end else if (p < 5) begin
        // The range ends and timestamps on either side of the clamping point for this offset.
        offset = zones[p];
        offset = offset * 60;
        send_epoch(0);
        send_epoch(SECONDS_TOP);
        if (offset > 0) begin
          send_epoch(offset - 1);
          send_epoch(offset);
        end else begin
          send_epoch(SECONDS_TOP + offset);
          send_epoch(SECONDS_TOP + offset + 1);
        end
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (p == 1 && i == RANDOM_PER_PHASE / 2) begin
          drain();
        end
        send_epoch(random_epoch(zones[p]));
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.expected_dates.size() == 0) begin
      $display("epoch_seconds_to_calendar_top: match");
    end else begin
      $display("epoch_seconds_to_calendar_top: mismatch");
    end
    $finish;
  end

endmodule
